[rtl/core/ccreg_pkg.sv]
// shared types and constants for the cc/cv supply drive regulator
// no dependencies; used by every module under rtl/core
package ccreg_pkg;

  localparam int unsigned SampleW   = 12;
  localparam int unsigned DriveW    = 12;
  localparam int unsigned GainW     = 3;
  localparam int unsigned StatusW   = 8;
  localparam int unsigned HoldW     = 8;
  localparam int unsigned HitsW     = 16;
  localparam int unsigned StepW     = 6;
  localparam int unsigned ProdW     = 17;
  localparam int unsigned VErrW     = 14;
  localparam int unsigned SumW      = 14;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 12;
  localparam int unsigned InTdataW  = 24;
  localparam int unsigned OutTdataW = 40;

  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [DriveW-1:0] DriveMax       = 12'hFFF;
  localparam logic [HoldW-1:0]  HoldoffSamples = 8'd128;

  // product thresholds, current branch
  localparam logic signed [ProdW-1:0] ProdMinusOne = -17'sd1;
  localparam logic signed [ProdW-1:0] ProdMinusTwo = -17'sd2;
  localparam logic signed [ProdW-1:0] ProdBigDrop  = -17'sd200;

  // voltage error thresholds
  localparam logic signed [VErrW-1:0] VErrDeadLow  = -14'sd2;
  localparam logic signed [VErrW-1:0] VErrDeadHigh = 14'sd3;
  localparam logic signed [VErrW-1:0] VErrCapHigh  = 14'sd10;
  localparam logic signed [VErrW-1:0] VErrBigDrop  = -14'sd200;

  localparam logic signed [StepW-1:0] StepZero     = 6'sd0;
  localparam logic signed [StepW-1:0] StepUp       = 6'sd1;
  localparam logic signed [StepW-1:0] StepMinusOne = -6'sd1;
  localparam logic signed [StepW-1:0] StepBigDrop  = -6'sd20;

  // status bit positions
  localparam int unsigned StCurMode  = 0;
  localparam int unsigned StOverVolt = 1;
  localparam int unsigned StVoltMode = 4;
  localparam int unsigned StHoldoff  = 5;

  localparam logic [StatusW-1:0] StatusCurKeep = 8'h0F;

  // reset values
  localparam logic [SampleW-1:0] RstTargetCurrent = 12'd100;
  localparam logic [SampleW-1:0] RstTargetVoltage = 12'd2000;
  localparam logic [GainW-1:0]   RstCurrentGain   = 3'd1;
  localparam logic [DriveW-1:0]  RstDriveFloor    = 12'd800;
  localparam logic [DriveW-1:0]  RstDrive         = 12'd800;
  localparam logic [HoldW-1:0]   RstHoldoff       = 8'd1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTargetCurrent = 3'd0,
    CfgTargetVoltage = 3'd1,
    CfgCurrentGain   = 3'd2,
    CfgDriveFloor    = 3'd3,
    CfgOutputEnable  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [SampleW-1:0] target_current;
    logic [SampleW-1:0] target_voltage;
    logic [GainW-1:0]   current_gain;
    logic [DriveW-1:0]  drive_floor;
    logic               output_enable;
  } cfg_t;

  // classified sample, front to back
  typedef struct packed {
    logic                    cur_branch;
    logic                    over_volt;
    logic signed [StepW-1:0] cur_step;
    logic signed [StepW-1:0] volt_step;
    logic                    volt_pos;
  } cmd_t;

endpackage

[rtl/core/ccreg_front.sv]
// front end: accepts sample pairs and classifies them into step commands
// depends on ccreg_pkg
module ccreg_front (
  input  logic                              s_tvalid_i,
  output logic                              s_tready_o,
  input  logic [ccreg_pkg::SampleW-1:0]     measured_current_i,
  input  logic [ccreg_pkg::SampleW-1:0]     measured_voltage_i,
  input  ccreg_pkg::cfg_t                   cfg_i,
  input  logic                              full_i,
  output logic                              push_o,
  output ccreg_pkg::cmd_t                   cmd_o
);

  logic signed [ccreg_pkg::SampleW:0]     cur_err;
  logic signed [ccreg_pkg::ProdW-1:0]     prod;
  logic signed [ccreg_pkg::VErrW-1:0]     volt_err;

  assign s_tready_o = !full_i;
  assign push_o     = s_tvalid_i && !full_i;

  always_comb begin
    cur_err = $signed({1'b0, cfg_i.target_current}) - $signed({1'b0, measured_current_i});
    prod    = $signed({{4{cur_err[ccreg_pkg::SampleW]}}, cur_err})
            * $signed({14'd0, cfg_i.current_gain});
    volt_err = $signed({2'b00, cfg_i.target_voltage}) - $signed({2'b00, measured_voltage_i})
             + $signed(14'sd1);

    cmd_o.cur_branch = prod[ccreg_pkg::ProdW-1];
    cmd_o.over_volt  = measured_voltage_i > cfg_i.target_voltage;

    // minus one and minus two both land in the deadband
    if (prod == ccreg_pkg::ProdMinusOne || prod == ccreg_pkg::ProdMinusTwo) begin
      cmd_o.cur_step = ccreg_pkg::StepZero;
    end else if (prod < ccreg_pkg::ProdBigDrop) begin
      cmd_o.cur_step = ccreg_pkg::StepBigDrop;
    end else begin
      cmd_o.cur_step = ccreg_pkg::StepMinusOne;
    end

    cmd_o.volt_pos = !volt_err[ccreg_pkg::VErrW-1] && (volt_err != '0);
    if (volt_err >= ccreg_pkg::VErrDeadLow && volt_err <= ccreg_pkg::VErrDeadHigh) begin
      cmd_o.volt_step = ccreg_pkg::StepZero;
    end else if (volt_err > ccreg_pkg::VErrCapHigh) begin
      cmd_o.volt_step = ccreg_pkg::StepUp;
    end else if (volt_err > ccreg_pkg::VErrDeadHigh) begin
      cmd_o.volt_step = volt_err[ccreg_pkg::StepW-1:0];
    end else if (volt_err < ccreg_pkg::VErrBigDrop) begin
      cmd_o.volt_step = ccreg_pkg::StepBigDrop;
    end else begin
      cmd_o.volt_step = ccreg_pkg::StepMinusOne;
    end
  end

endmodule

[rtl/core/ccreg_queue.sv]
// short command queue between front and back end
// depends on ccreg_pkg
module ccreg_queue #(
  parameter int unsigned Depth = ccreg_pkg::QueueDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ccreg_pkg::cmd_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output ccreg_pkg::cmd_t pop_data_o,
  output logic            empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  ccreg_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o     = cnt_q == FullCnt;
  assign empty_o    = cnt_q == '0;
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/core/ccreg_back.sv]
// back end: regulator state, step caps, drive clamp and result register
// depends on ccreg_pkg
module ccreg_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ccreg_pkg::cfg_t                   cfg_i,
  input  ccreg_pkg::cmd_t                   cmd_i,
  input  logic                              empty_i,
  output logic                              pop_o,
  output logic                              m_tvalid_o,
  input  logic                              m_tready_i,
  output logic [ccreg_pkg::DriveW-1:0]      drive_out_o,
  output logic                              drive_written_o,
  output logic                              current_mode_o,
  output logic [ccreg_pkg::StatusW-1:0]     loop_status_o,
  output logic [ccreg_pkg::HitsW-1:0]       settled_count_o
);

  logic [ccreg_pkg::DriveW-1:0]  drive_q, drive_d;
  logic [ccreg_pkg::DriveW-1:0]  applied_q, applied_d;
  logic [ccreg_pkg::HoldW-1:0]   hold_q, hold_d;
  logic [ccreg_pkg::StatusW-1:0] status_q, status_d;
  logic [ccreg_pkg::HitsW-1:0]   hits_q, hits_d;
  logic                          written_d;
  logic signed [ccreg_pkg::StepW-1:0] step;
  logic signed [ccreg_pkg::SumW-1:0]  sum;

  logic                          out_valid_q;
  logic [ccreg_pkg::DriveW-1:0]  out_drive_q;
  logic                          out_written_q;
  logic                          out_cur_mode_q;
  logic [ccreg_pkg::StatusW-1:0] out_status_q;
  logic [ccreg_pkg::HitsW-1:0]   out_hits_q;

  assign pop_o = !empty_i && (!out_valid_q || m_tready_i);

  always_comb begin
    status_d = status_q;
    hold_d   = hold_q;
    step     = cmd_i.volt_step;
    if (cmd_i.cur_branch) begin
      status_d = status_q & ccreg_pkg::StatusCurKeep;
      status_d[ccreg_pkg::StCurMode] = 1'b1;
      if (cmd_i.over_volt) begin
        // forced -20 is capped to -1, hold-off dropped
        status_d[ccreg_pkg::StOverVolt] = 1'b1;
        hold_d = '0;
        step   = ccreg_pkg::StepMinusOne;
      end else begin
        hold_d = ccreg_pkg::HoldoffSamples;
        step   = cmd_i.cur_step;
      end
    end else begin
      status_d[ccreg_pkg::StCurMode]  = 1'b0;
      status_d[ccreg_pkg::StOverVolt] = 1'b0;
      status_d[ccreg_pkg::StHoldoff]  = 1'b0;
      status_d[ccreg_pkg::StVoltMode] = 1'b1;
      if (hold_q != '0) begin
        // hold-off: increases blocked
        status_d[ccreg_pkg::StHoldoff] = 1'b1;
        hold_d = hold_q - 1'b1;
        if (cmd_i.volt_pos) begin
          step = ccreg_pkg::StepZero;
        end
      end
    end

    sum = $signed({2'b00, drive_q}) + $signed({{8{step[ccreg_pkg::StepW-1]}}, step});

    hits_d    = hits_q;
    drive_d   = drive_q;
    applied_d = applied_q;
    written_d = 1'b0;
    if (step == ccreg_pkg::StepZero) begin
      hits_d = hits_q + 1'b1;
    end else begin
      written_d = 1'b1;
      if (sum > $signed({2'b00, ccreg_pkg::DriveMax})) begin
        drive_d = ccreg_pkg::DriveMax;
      end else if (sum < $signed({2'b00, cfg_i.drive_floor})) begin
        drive_d = cfg_i.drive_floor;
      end else begin
        drive_d = sum[ccreg_pkg::DriveW-1:0];
      end
      applied_d = cfg_i.output_enable ? drive_d : cfg_i.drive_floor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_q     <= ccreg_pkg::RstDrive;
      applied_q   <= ccreg_pkg::RstDrive;
      hold_q      <= ccreg_pkg::RstHoldoff;
      status_q    <= '0;
      hits_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        drive_q     <= drive_d;
        applied_q   <= applied_d;
        hold_q      <= hold_d;
        status_q    <= status_d;
        hits_q      <= hits_d;
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_drive_q    <= applied_d;
      out_written_q  <= written_d;
      out_cur_mode_q <= hold_d != '0;
      out_status_q   <= status_d;
      out_hits_q     <= hits_d;
    end
  end

  assign m_tvalid_o      = out_valid_q;
  assign drive_out_o     = out_drive_q;
  assign drive_written_o = out_written_q;
  assign current_mode_o  = out_cur_mode_q;
  assign loop_status_o   = out_status_q;
  assign settled_count_o = out_hits_q;

endmodule

[rtl/core/cc_cv_supply_dac_regulator.sv]
// Constant-current / constant-voltage regulator for a 12-bit supply drive. One
// sample pair (current, voltage) is taken per beat and every sample yields one
// result beat. Throughput is one sample per clock while the queue is not full. A
// sample is classified by the front end in the accept cycle and written into a
// small command queue; the back end, which owns the drive, hold-off, status and
// deadband counters, retires one command a cycle into the output register while
// that register is empty or being read. Configuration registers are written
// through the plain write port and are meant to change only while no sample is
// in flight. Reset needs no clearing pass.
// top level: configuration registers, front end, command queue, back end
// depends on ccreg_pkg, ccreg_front, ccreg_queue, ccreg_back
module cc_cv_supply_dac_regulator #(
  parameter int unsigned QueueDepth = ccreg_pkg::QueueDepthDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_tvalid_i,
  output logic                               s_tready_o,
  // [11:0] measured_current, [23:12] measured_voltage
  input  logic [ccreg_pkg::InTdataW-1:0]     s_tdata_i,
  output logic                               m_tvalid_o,
  input  logic                               m_tready_i,
  // [11:0] drive_out, [12] drive_written, [13] current_mode,
  // [21:14] loop_status, [37:22] settled_count, [39:38] zero
  output logic [ccreg_pkg::OutTdataW-1:0]    m_tdata_o,
  input  logic                               cfg_we_i,
  input  logic [ccreg_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [ccreg_pkg::CfgDataW-1:0]     cfg_data_i
);

  ccreg_pkg::cfg_t cfg_q, cfg_d;
  ccreg_pkg::cmd_t push_cmd, pop_cmd;
  logic            push, pop, full, empty;

  logic [ccreg_pkg::DriveW-1:0]  drive_out;
  logic                          drive_written;
  logic                          current_mode;
  logic [ccreg_pkg::StatusW-1:0] loop_status;
  logic [ccreg_pkg::HitsW-1:0]   settled_count;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (ccreg_pkg::cfg_idx_e'(cfg_idx_i))
        ccreg_pkg::CfgTargetCurrent: cfg_d.target_current = cfg_data_i;
        ccreg_pkg::CfgTargetVoltage: cfg_d.target_voltage = cfg_data_i;
        ccreg_pkg::CfgCurrentGain:   cfg_d.current_gain   = cfg_data_i[ccreg_pkg::GainW-1:0];
        ccreg_pkg::CfgDriveFloor:    cfg_d.drive_floor    = cfg_data_i;
        ccreg_pkg::CfgOutputEnable:  cfg_d.output_enable  = cfg_data_i[0];
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_current <= ccreg_pkg::RstTargetCurrent;
      cfg_q.target_voltage <= ccreg_pkg::RstTargetVoltage;
      cfg_q.current_gain   <= ccreg_pkg::RstCurrentGain;
      cfg_q.drive_floor    <= ccreg_pkg::RstDriveFloor;
      cfg_q.output_enable  <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ccreg_front u_front (
    .s_tvalid_i         (s_tvalid_i),
    .s_tready_o         (s_tready_o),
    .measured_current_i (s_tdata_i[11:0]),
    .measured_voltage_i (s_tdata_i[23:12]),
    .cfg_i              (cfg_q),
    .full_i             (full),
    .push_o             (push),
    .cmd_o              (push_cmd)
  );

  ccreg_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_cmd),
    .empty_o     (empty)
  );

  ccreg_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .cmd_i           (pop_cmd),
    .empty_i         (empty),
    .pop_o           (pop),
    .m_tvalid_o      (m_tvalid_o),
    .m_tready_i      (m_tready_i),
    .drive_out_o     (drive_out),
    .drive_written_o (drive_written),
    .current_mode_o  (current_mode),
    .loop_status_o   (loop_status),
    .settled_count_o (settled_count)
  );

  assign m_tdata_o = {2'b00, settled_count, loop_status, current_mode, drive_written,
                      drive_out};

endmodule

[bench/tb_cc_cv_supply_dac_regulator.sv]
// self-checking bench for cc_cv_supply_dac_regulator: sample pairs in, one drive result out
// keeps its own regulator model and checks every result beat field by field
// depends on ccreg_pkg and the regulator rtl
`timescale 1ns / 1ps

module tb_cc_cv_supply_dac_regulator;

  localparam int IdleCutoff   = 3000;
  localparam int StallCycles  = 300;
  localparam int IdlePercent  = 34;
  localparam int BigDropLimit = -200;
  localparam int BigDropStep  = -20;
  localparam int CapHigh      = 10;
  localparam int SettledRun   = 24;

  // packed from the top bit down, so drive lands in the lowest bits as on tdata
  typedef struct packed {
    logic [ccreg_pkg::HitsW-1:0]   hits;
    logic [ccreg_pkg::StatusW-1:0] status;
    logic                          cur_mode;
    logic                          written;
    logic [ccreg_pkg::DriveW-1:0]  drive;
  } drive_result_t;

  logic                            clk_i      = 1'b0;
  logic                            rst_ni     = 1'b0;
  logic                            s_tvalid_i = 1'b0;
  logic                            s_tready_o;
  logic [ccreg_pkg::InTdataW-1:0]  s_tdata_i  = '0;
  logic                            m_tvalid_o;
  logic                            m_tready_i = 1'b0;
  logic [ccreg_pkg::OutTdataW-1:0] m_tdata_o;
  logic                            cfg_we_i   = 1'b0;
  logic [ccreg_pkg::CfgIdxW-1:0]   cfg_idx_i  = '0;
  logic [ccreg_pkg::CfgDataW-1:0]  cfg_data_i = '0;

  cc_cv_supply_dac_regulator i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // regulator model state
  ccreg_pkg::cfg_t               regs;
  logic [ccreg_pkg::DriveW-1:0]  drive_setting;
  logic [ccreg_pkg::DriveW-1:0]  applied_drive;
  logic [ccreg_pkg::HoldW-1:0]   holdoff_left;
  logic [ccreg_pkg::StatusW-1:0] status_bits;
  logic [ccreg_pkg::HitsW-1:0]   settled_hits;

  drive_result_t expected_drive_q[$];

  int  n_sent     = 0;
  int  n_done     = 0;
  int  n_errors   = 0;
  int  n_settings = 0;
  bit  gaps_on    = 1'b1;
  int  hold_req   = 0;

  function automatic drive_result_t regulate_sample(logic [ccreg_pkg::SampleW-1:0] cur,
                                                    logic [ccreg_pkg::SampleW-1:0] volt);
    drive_result_t res;
    int            err;
    int            d;
    res.written = 1'b0;
    err = (int'(regs.target_current) - int'(cur)) * int'(regs.current_gain);
    if (err < 0) begin
      status_bits[7:4] = '0;
      status_bits[ccreg_pkg::StCurMode] = 1'b1;
      if (err > -2) err = 0;
      holdoff_left = ccreg_pkg::HoldoffSamples;
      if (volt > regs.target_voltage) begin
        status_bits[ccreg_pkg::StOverVolt] = 1'b1;
        err = BigDropStep;
        holdoff_left = '0;
      end
    end else begin
      status_bits[ccreg_pkg::StCurMode]  = 1'b0;
      status_bits[ccreg_pkg::StOverVolt] = 1'b0;
      status_bits[2]                     = 1'b0;
      status_bits[ccreg_pkg::StHoldoff]  = 1'b0;
      status_bits[ccreg_pkg::StVoltMode] = 1'b1;
      err = 1 + int'(regs.target_voltage) - int'(volt);
      if (holdoff_left != 0) begin
        // hold-off after current limiting: only decreases allowed
        status_bits[ccreg_pkg::StHoldoff] = 1'b1;
        holdoff_left = holdoff_left - 1'b1;
        if (err > 0) err = 0;
      end
    end
    if (err > -3 && err < 4) err = 0;
    if (err == 0) begin
      settled_hits = settled_hits + 1'b1;
    end else begin
      if (err > CapHigh) err = 1;
      if (err < BigDropLimit) err = BigDropStep;
      else if (err < -1) err = -1;
      d = int'(drive_setting) + err;
      if (d > int'(ccreg_pkg::DriveMax)) d = int'(ccreg_pkg::DriveMax);
      if (d < int'(regs.drive_floor)) d = int'(regs.drive_floor);
      drive_setting = d[ccreg_pkg::DriveW-1:0];
      applied_drive = regs.output_enable ? drive_setting : regs.drive_floor;
      res.written = 1'b1;
    end
    res.drive    = applied_drive;
    res.cur_mode = (holdoff_left != 0);
    res.status   = status_bits;
    res.hits     = settled_hits;
    return res;
  endfunction

  function automatic void check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      n_errors++;
    end
  endfunction

  // model reset values
  initial begin
    regs.target_current = ccreg_pkg::RstTargetCurrent;
    regs.target_voltage = ccreg_pkg::RstTargetVoltage;
    regs.current_gain   = ccreg_pkg::RstCurrentGain;
    regs.drive_floor    = ccreg_pkg::RstDriveFloor;
    regs.output_enable  = 1'b0;
    drive_setting       = ccreg_pkg::RstDrive;
    applied_drive       = ccreg_pkg::RstDrive;
    holdoff_left        = ccreg_pkg::RstHoldoff;
    status_bits         = '0;
    settled_hits        = '0;
  end

  // result checking, register tracking and prediction on each accepted beat
  always @(posedge clk_i) begin
    drive_result_t want;
    drive_result_t got;
    if (rst_ni) begin
      if (m_tvalid_o && m_tready_i) begin
        got = m_tdata_o[37:0];
        if (expected_drive_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, got %h", $time, got);
          n_errors++;
        end else begin
          want = expected_drive_q.pop_front();
          check_field("drive_out", 32'(want.drive), 32'(got.drive));
          check_field("drive_written", 32'(want.written), 32'(got.written));
          check_field("current_mode", 32'(want.cur_mode), 32'(got.cur_mode));
          check_field("loop_status", 32'(want.status), 32'(got.status));
          check_field("settled_count", 32'(want.hits), 32'(got.hits));
          check_field("tdata pad", 0, 32'(m_tdata_o[ccreg_pkg::OutTdataW-1:38]));
        end
        n_done++;
      end
      if (cfg_we_i) begin
        case (ccreg_pkg::cfg_idx_e'(cfg_idx_i))
          ccreg_pkg::CfgTargetCurrent:
            regs.target_current = cfg_data_i[ccreg_pkg::SampleW-1:0];
          ccreg_pkg::CfgTargetVoltage:
            regs.target_voltage = cfg_data_i[ccreg_pkg::SampleW-1:0];
          ccreg_pkg::CfgCurrentGain:
            regs.current_gain   = cfg_data_i[ccreg_pkg::GainW-1:0];
          ccreg_pkg::CfgDriveFloor:
            regs.drive_floor    = cfg_data_i[ccreg_pkg::DriveW-1:0];
          ccreg_pkg::CfgOutputEnable:
            regs.output_enable  = cfg_data_i[0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_o)
        expected_drive_q.push_back(regulate_sample(s_tdata_i[11:0], s_tdata_i[23:12]));
    end
  end

  // receiver: random stalls, plus a long hold when the test asks for one
  always @(posedge clk_i) begin
    static int hold_seen = 0;
    static int hold_left = 0;
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = StallCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready_i <= 1'b0;
    end else begin
      m_tready_i <= !gaps_on || ($urandom_range(0, 99) >= IdlePercent);
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    static int quiet = 0;
    if (rst_ni) begin
      if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) quiet = 0;
      else quiet++;
      if (quiet >= IdleCutoff) begin
        $display("%0t: no progress for %0d cycles", $time, quiet);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_pair(int cur, int volt);
    while (gaps_on && $urandom_range(0, 99) < IdlePercent) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= {volt[ccreg_pkg::SampleW-1:0], cur[ccreg_pkg::SampleW-1:0]};
    do @(posedge clk_i); while (!s_tready_o);
    n_sent++;
  endtask

  // stop offering and wait until every result beat is back
  task automatic settle();
    s_tvalid_i <= 1'b0;
    while (n_done != n_sent) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(ccreg_pkg::cfg_idx_e idx, int value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[ccreg_pkg::CfgDataW-1:0];
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_settings(int ti, int tv, int gain, int floor_v, int en);
    write_reg(ccreg_pkg::CfgTargetCurrent, ti);
    write_reg(ccreg_pkg::CfgTargetVoltage, tv);
    write_reg(ccreg_pkg::CfgCurrentGain, gain);
    write_reg(ccreg_pkg::CfgDriveFloor, floor_v);
    write_reg(ccreg_pkg::CfgOutputEnable, en);
    n_settings++;
  endtask

  function automatic int clip_sample(int v);
    if (v < 0) return 0;
    if (v > 4095) return 4095;
    return v;
  endfunction

  task automatic t_directed();
    // reset settings: output disabled, floor drives the output
    send_pair(0, 0);
    send_pair(0, 1990);
    send_pair(101, 0);
    send_pair(4095, 4095);
    send_pair(4095, 0);
    settle();
    // hold-off blocks a large increase; zero error in the voltage branch
    apply_settings(4095, 4095, 7, 0, 1);
    send_pair(0, 0);
    send_pair(4095, 4095);
    settle();
    // zero gain always picks the voltage branch
    apply_settings(2000, 1000, 0, 0, 1);
    send_pair(4095, 1000);
    settle();
    // step caps around the deadband edges and the big drop limit
    apply_settings(100, 1000, 1, 0, 1);
    send_pair(200, 2000);
    send_pair(0, 995);
    send_pair(0, 997);
    send_pair(0, 998);
    send_pair(0, 1003);
    send_pair(0, 1004);
    send_pair(0, 1200);
    send_pair(0, 1201);
    send_pair(0, 1202);
    settle();
    // floor above drive clamps up at the next write, then the top clamp
    write_reg(ccreg_pkg::CfgDriveFloor, 4095);
    send_pair(0, 1004);
    send_pair(0, 500);
    settle();
    write_reg(ccreg_pkg::CfgDriveFloor, 0);
    send_pair(0, 3000);
    settle();
  endtask

  task automatic random_sample_run(int count);
    int cur;
    int volt;
    int ti;
    int tv;
    for (int n = 0; n < count; n++) begin
      ti = int'(regs.target_current);
      tv = int'(regs.target_voltage);
      case ($urandom_range(0, 9))
        0, 1: begin
          cur  = $urandom_range(0, 4095);
          volt = $urandom_range(0, 4095);
        end
        2, 3, 4: begin
          cur  = clip_sample(ti + $urandom_range(0, 6) - 3);
          volt = clip_sample(tv + $urandom_range(0, 40) - 20);
        end
        5, 6, 7: begin
          cur  = $urandom_range(0, ti);
          volt = clip_sample(tv + $urandom_range(0, 24) - 12);
        end
        8: begin
          cur  = $urandom_range(ti, 4095);
          volt = clip_sample(tv + $urandom_range(0, 600) - 300);
        end
        default: begin
          cur  = $urandom_range(0, 1) ? 4095 : 0;
          volt = $urandom_range(0, 1) ? 4095 : 0;
        end
      endcase
      send_pair(cur, volt);
    end
    settle();
  endtask

  task automatic t_random();
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: apply_settings(0, 0, 7, 0, 1);
        1: apply_settings(4095, 4095, 1, 4095, 1);
        2: apply_settings($urandom_range(0, 4095), $urandom_range(0, 4095), 0,
                          $urandom_range(0, 4095), $urandom_range(0, 1));
        default: apply_settings($urandom_range(0, 4095), $urandom_range(0, 4095),
                                $urandom_range(1, 7), $urandom_range(0, 1200),
                                $urandom_range(0, 1));
      endcase
      gaps_on = (p != 3);
      random_sample_run(120);
    end
    gaps_on = 1'b1;
  endtask

  task automatic t_backpressure();
    apply_settings($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(1, 7),
                   $urandom_range(0, 1000), 1);
    gaps_on = 1'b0;
    hold_req++;
    random_sample_run(48);
    gaps_on = 1'b1;
  endtask

  task automatic t_settled_count();
    // current below target and voltage at target: every beat lands in the deadband
    apply_settings(50, 2048, 3, 800, 1);
    gaps_on = 1'b0;
    for (int n = 0; n < SettledRun; n++) send_pair(0, 2048);
    settle();
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    t_directed();
    t_random();
    t_backpressure();
    t_settled_count();
    repeat (10) @(posedge clk_i);
    $display("summary: %0d samples checked over %0d register settings", n_done, n_settings);
    $display("  incl. zero gain, caps, floor and top clamps, long output stall, settled run");
    if (n_errors == 0 && expected_drive_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results outstanding", n_errors, expected_drive_q.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
